[src/ccm_pkg.sv]
package ccm_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned NUM_COEF    = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_PAIR_A = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAIR_B = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAIR_C = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAIR_D = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST   = 3'd4;

  localparam logic [31:0] F32_QNAN    = 32'h7fc0_0000;
  localparam logic [15:0] HALF_QNAN   = 16'h7e00;

  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] alpha;
  } pix_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha;
  } res_t;

  function automatic logic [31:0] half_widen(input logic [15:0] h);
    logic [3:0] s;
    logic [9:0] m;
    logic [31:0] r;
    s = 4'd0;
    m = h[9:0];
    for (int i = 0; i < 10; i++) begin
      if (h[i]) s = 4'(10 - i);
    end
    if (h[14:10] == 5'd0) begin
      if (m == 10'd0) begin
        r = {h[15], 31'd0};
      end else begin
        m = m << s;
        r = {h[15], 8'(8'd113 - {4'd0, s}), m, 13'd0};
      end
    end else if (h[14:10] == 5'h1f) begin
      r = {h[15], 8'hff, m, 13'd0};
    end else begin
      r = {h[15], 8'({3'd0, h[14:10]} + 8'd112), m, 13'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] f32_round(input logic sgn, input logic signed [10:0] ex,
                                            input logic [26:0] m);
    logic [31:0] wide;
    logic [31:0] mask;
    logic [26:0] mm;
    logic [24:0] sig;
    logic up;
    logic [5:0] sh;
    logic signed [10:0] e2;
    logic [31:0] r;
    if (ex < 11'sd1) begin
      if (ex < -11'sd29) sh = 6'd31;
      else sh = 6'(11'sd1 - ex);
      wide = {5'd0, m};
      mask = ~(32'hffff_ffff << sh);
      mm = 27'(wide >> sh) | {26'd0, |(wide & mask)};
      up = mm[2] & ((|mm[1:0]) | mm[3]);
      sig = {1'b0, mm[26:3]} + {24'd0, up};
      r = {sgn, 7'd0, sig[23], sig[22:0]};
    end else begin
      up = m[2] & ((|m[1:0]) | m[3]);
      sig = {1'b0, m[26:3]} + {24'd0, up};
      e2 = ex + $signed({10'd0, sig[24]});
      if (e2 >= 11'sd255) r = {sgn, 8'hff, 23'd0};
      else r = {sgn, e2[7:0], sig[24] ? 23'd0 : sig[22:0]};
    end
    return r;
  endfunction

  function automatic logic [15:0] half_narrow(input logic [31:0] f);
    logic sgn;
    logic [7:0] ex;
    logic [22:0] m;
    logic signed [9:0] e;
    logic [31:0] m24;
    logic [4:0] sh;
    logic [31:0] hm;
    logic [31:0] rem;
    logic [31:0] half;
    logic [15:0] h;
    logic [15:0] r;
    sgn = f[31];
    ex = f[30:23];
    m = f[22:0];
    e = $signed({2'd0, ex}) - 10'sd112;
    if (ex == 8'hff) begin
      r = (m != 23'd0) ? HALF_QNAN : {sgn, 15'h7c00};
    end else if (e >= 10'sd31) begin
      r = {sgn, 15'h7c00};
    end else if (e <= 10'sd0) begin
      if (e < -10'sd10) begin
        r = {sgn, 15'd0};
      end else begin
        m24 = {8'd0, 1'b1, m};
        sh = 5'(10'sd14 - e);
        hm = m24 >> sh;
        rem = m24 & ((32'd1 << sh) - 32'd1);
        half = 32'd1 << (sh - 5'd1);
        if (rem > half || (rem == half && hm[0])) hm = hm + 32'd1;
        r = {sgn, 4'd0, hm[10:0]};
      end
    end else begin
      h = {sgn, e[4:0], m[22:13]};
      if (m[12:0] > 13'h1000 || (m[12:0] == 13'h1000 && h[0])) h = h + 16'd1;
      r = h;
    end
    return r;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] p);
    logic [5:0] pos;
    pos = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) pos = 6'(i);
    end
    return 6'(6'd47 - pos);
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] p);
    logic [4:0] pos;
    pos = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (p[i]) pos = 5'(i);
    end
    return 5'(5'd26 - pos);
  endfunction

endpackage

[src/ccm_fmul.sv]
module ccm_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic        sgn1;
  logic signed [10:0] exp1;
  logic [47:0] prod1;
  logic        spec1;
  logic [31:0] spec_val1;

  logic        sgn2;
  logic signed [10:0] exp2;
  logic [47:0] norm2;
  logic        spec2;
  logic [31:0] spec_val2;

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s;
  logic [23:0] ma, mb;
  logic [7:0] ea, eb;
  logic [5:0] lz;

  always_comb begin
    a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    s      = a[31] ^ b[31];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    lz     = ccm_pkg::lzc48(prod1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sgn1  <= s;
      exp1  <= $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126;
      prod1 <= ma * mb;
      spec1 <= a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
        spec_val1 <= ccm_pkg::F32_QNAN;
      end else if (a_inf || b_inf) begin
        spec_val1 <= {s, 8'hff, 23'd0};
      end else begin
        spec_val1 <= {s, 31'd0};
      end

      sgn2      <= sgn1;
      exp2      <= exp1 - $signed({5'd0, lz});
      norm2     <= prod1 << lz;
      spec2     <= spec1;
      spec_val2 <= spec_val1;

      if (spec2) begin
        y <= spec_val2;
      end else begin
        y <= ccm_pkg::f32_round(sgn2, exp2, {norm2[47:22], |norm2[21:0]});
      end
    end
  end

endmodule

[src/ccm_fadd.sv]
module ccm_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic        sgn1, sub1, spec1, zsgn1;
  logic [7:0]  exp1;
  logic [23:0] mbig1, msml1;
  logic [7:0]  diff1;
  logic [31:0] spec_val1;

  logic        sgn2, spec2, zsgn2;
  logic [7:0]  exp2;
  logic [27:0] sum2;
  logic [31:0] spec_val2;

  logic        sgn3, spec3, zero3, zsgn3;
  logic signed [10:0] exp3;
  logic [26:0] m3;
  logic [31:0] spec_val3;

  logic a_nan, b_nan, a_inf, b_inf, swap;
  logic [31:0] big, sml;
  logic [7:0] eb_eff, es_eff;
  logic [31:0] wide, mask;
  logic [26:0] aligned;
  logic [26:0] big27;
  logic [4:0] lz;

  always_comb begin
    a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    swap   = b[30:0] > a[30:0];
    big    = swap ? b : a;
    sml    = swap ? a : b;
    eb_eff = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es_eff = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];

    wide    = {5'd0, msml1, 3'd0};
    mask    = (diff1 > 8'd27) ? 32'hffff_ffff : ~(32'hffff_ffff << diff1[4:0]);
    aligned = (diff1 > 8'd27) ? 27'd0 : 27'(wide >> diff1[4:0]);
    aligned = aligned | {26'd0, |(wide & mask)};
    big27   = {mbig1, 3'd0};

    lz = ccm_pkg::lzc27(sum2[26:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sgn1  <= big[31];
      sub1  <= a[31] ^ b[31];
      zsgn1 <= a[31] & b[31];
      exp1  <= eb_eff;
      mbig1 <= {big[30:23] != 8'd0, big[22:0]};
      msml1 <= {sml[30:23] != 8'd0, sml[22:0]};
      diff1 <= eb_eff - es_eff;
      spec1 <= a_nan || b_nan || a_inf || b_inf;
      if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
        spec_val1 <= ccm_pkg::F32_QNAN;
      end else if (a_inf) begin
        spec_val1 <= a;
      end else begin
        spec_val1 <= b;
      end

      sgn2      <= sgn1;
      zsgn2     <= zsgn1;
      exp2      <= exp1;
      sum2      <= sub1 ? ({1'b0, big27} - {1'b0, aligned}) : ({1'b0, big27} + {1'b0, aligned});
      spec2     <= spec1;
      spec_val2 <= spec_val1;

      sgn3      <= sgn2;
      zsgn3     <= zsgn2;
      zero3     <= (sum2 == 28'd0);
      spec3     <= spec2;
      spec_val3 <= spec_val2;
      if (sum2[27]) begin
        m3   <= {sum2[27:2], |sum2[1:0]};
        exp3 <= $signed({3'd0, exp2}) + 11'sd1;
      end else begin
        m3   <= sum2[26:0] << lz;
        exp3 <= $signed({3'd0, exp2}) - $signed({6'd0, lz});
      end

      if (spec3) begin
        y <= spec_val3;
      end else if (zero3) begin
        y <= {zsgn3, 31'd0};
      end else begin
        y <= ccm_pkg::f32_round(sgn3, exp3, m3);
      end
    end
  end

endmodule

[src/color_matrix_3x3_half_float.sv]
// 3x3 color correction on RGBA pixels with binary16 channels. Red, green and
// blue are widened to binary32, each output row is (c0*r + c1*g) + c2*b with
// every multiply and add rounded to nearest even in single precision, and the
// result is narrowed to binary16 (NaN becomes 0x7e00); alpha passes through.
// One pixel is accepted per clock while the result side is not stalled; the
// pipeline is the input register, the pipelined multiplier (3 stages), the
// two chained adders (4 stages each) and the output narrowing register.
// Backpressure on the result side holds the whole pipeline.
// Coefficients are written through wr_en/wr_index/wr_data while the block is
// idle; indexes 0..3 each load two coefficients (low word first, row-major),
// index 4 loads the last one, higher indexes are ignored. All reset to +0.0.
module color_matrix_3x3_half_float (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pix_valid,
  output logic                             pix_stall,
  input  ccm_pkg::pix_t                    pix,
  output logic                             res_valid,
  input  logic                             res_stall,
  output ccm_pkg::res_t                    res,
  input  logic                             wr_en,
  input  logic [ccm_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [ccm_pkg::CFG_DATA_W-1:0]   wr_data
);

  localparam int unsigned DEPTH = 13;

  logic [31:0] coef [ccm_pkg::NUM_COEF];
  logic [DEPTH-1:0] vld;
  logic en;
  ccm_pkg::pix_t pix0;
  logic [15:0] alpha_line [11];
  logic [31:0] chan [3];
  logic [31:0] s1 [3];

  assign en        = !(vld[DEPTH-1] && res_stall);
  assign pix_stall = !en;
  assign res_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ccm_pkg::NUM_COEF; i++) coef[i] <= 32'd0;
    end else if (wr_en) begin
      case (wr_index)
        ccm_pkg::CFG_PAIR_A: begin
          coef[0] <= wr_data[31:0];
          coef[1] <= wr_data[63:32];
        end
        ccm_pkg::CFG_PAIR_B: begin
          coef[2] <= wr_data[31:0];
          coef[3] <= wr_data[63:32];
        end
        ccm_pkg::CFG_PAIR_C: begin
          coef[4] <= wr_data[31:0];
          coef[5] <= wr_data[63:32];
        end
        ccm_pkg::CFG_PAIR_D: begin
          coef[6] <= wr_data[31:0];
          coef[7] <= wr_data[63:32];
        end
        ccm_pkg::CFG_LAST: begin
          coef[8] <= wr_data[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], pix_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix0 <= pix;
      alpha_line[0] <= pix0.alpha;
      for (int i = 1; i < 11; i++) alpha_line[i] <= alpha_line[i-1];
      res.red_out   <= ccm_pkg::half_narrow(s1[0]);
      res.green_out <= ccm_pkg::half_narrow(s1[1]);
      res.blue_out  <= ccm_pkg::half_narrow(s1[2]);
      res.alpha     <= alpha_line[10];
    end
  end

  assign chan[0] = ccm_pkg::half_widen(pix0.red_in);
  assign chan[1] = ccm_pkg::half_widen(pix0.green_in);
  assign chan[2] = ccm_pkg::half_widen(pix0.blue_in);

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic [31:0] p [3];
    logic [31:0] s0;
    logic [31:0] p2_line [4];

    for (genvar k = 0; k < 3; k++) begin : g_mul
      ccm_fmul u_mul (
        .clk (clk),
        .en  (en),
        .a   (coef[3*r+k]),
        .b   (chan[k]),
        .y   (p[k])
      );
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p2_line[0] <= p[2];
        for (int i = 1; i < 4; i++) p2_line[i] <= p2_line[i-1];
      end
    end

    ccm_fadd u_add0 (
      .clk (clk),
      .en  (en),
      .a   (p[0]),
      .b   (p[1]),
      .y   (s0)
    );

    ccm_fadd u_add1 (
      .clk (clk),
      .en  (en),
      .a   (s0),
      .b   (p2_line[3]),
      .y   (s1[r])
    );
  end

`ifndef SYNTHESIS
  a_nan_canonical: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.red_out[14:10] == 5'h1f) && (res.red_out[9:0] != 10'd0)
    |-> res.red_out == ccm_pkg::HALF_QNAN)
    else $error("red result is a noncanonical nan");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && ($countones(vld) == 0))
    else $error("pipeline not empty after reset");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> res_valid && res_stall)
    else $error("request stalled without result backpressure");
`endif

endmodule

[tb/tb_color_matrix_3x3_half_float.sv]
`timescale 1ns / 1ps

module tb_color_matrix_3x3_half_float;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_stall;
  ccm_pkg::pix_t pix = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  ccm_pkg::res_t res;
  logic wr_en = 1'b0;
  logic [ccm_pkg::CFG_INDEX_W-1:0] wr_index = '0;
  logic [ccm_pkg::CFG_DATA_W-1:0] wr_data = '0;

  logic [31:0] coef [ccm_pkg::NUM_COEF];
  logic [31:0] next_coef [ccm_pkg::NUM_COEF];
  ccm_pkg::res_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;

  color_matrix_3x3_half_float dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always #5 clk = ~clk;

  // round a value sig * 2^e to a float with fw fraction bits, nearest even
  function automatic logic [31:0] round_pack(input logic s, input logic [63:0] sig,
                                             input int e, input int fw, input int bias,
                                             input int w);
    int p;
    int be;
    int sh;
    logic [127:0] mm;
    logic [127:0] rem;
    logic [127:0] half;
    logic [31:0] sbit;
    sbit = 32'(s) << (w - 1);
    if (sig == 64'd0) return sbit;
    p = 0;
    for (int i = 0; i < 64; i++) if (sig[i]) p = i;
    be = e + p + bias;
    if (be >= 1) sh = p - fw;
    else begin
      sh = p - fw + 1 - be;
      be = 0;
    end
    if (sh > 70) return sbit;
    if (sh <= 0) mm = {64'd0, sig} << (-sh);
    else begin
      mm = {64'd0, sig} >> sh;
      rem = {64'd0, sig} & ((128'd1 << sh) - 128'd1);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && mm[0])) mm = mm + 128'd1;
    end
    if (be == 0) begin
      if (mm[fw]) be = 1;
    end else if (mm[fw + 1]) begin
      mm = mm >> 1;
      be++;
    end
    if (be >= 2 * bias + 1) return sbit | (32'(2 * bias + 1) << fw);
    return sbit | (32'(be) << fw) | (32'(mm) & ((32'd1 << fw) - 32'd1));
  endfunction

  function automatic logic is_nan(input logic [31:0] f);
    return f[30:23] == 8'hff && f[22:0] != 23'd0;
  endfunction

  function automatic logic is_inf(input logic [31:0] f);
    return f[30:23] == 8'hff && f[22:0] == 23'd0;
  endfunction

  function automatic logic [63:0] sig_of(input logic [31:0] f);
    return (f[30:23] == 8'd0) ? {41'd0, f[22:0]} : {40'd0, 1'b1, f[22:0]};
  endfunction

  function automatic int exp_of(input logic [31:0] f);
    return (f[30:23] == 8'd0) ? -149 : int'(f[30:23]) - 150;
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return ccm_pkg::F32_QNAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return ccm_pkg::F32_QNAN;
      return {s, 8'hff, 23'd0};
    end
    return round_pack(s, sig_of(a) * sig_of(b), exp_of(a) + exp_of(b), 23, 127, 32);
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] sum;
    logic s;
    int diff;
    if (is_nan(a) || is_nan(b)) return ccm_pkg::F32_QNAN;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return ccm_pkg::F32_QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    if (exp_of(a) < exp_of(b)) begin
      t = a;
      a = b;
      b = t;
    end
    diff = exp_of(a) - exp_of(b);
    ma = sig_of(a) << 30;
    mb = sig_of(b) << 30;
    if (diff > 60) mb = {63'd0, mb != 64'd0};
    else mb = (mb >> diff) | {63'd0, (mb & ((64'd1 << diff) - 64'd1)) != 64'd0};
    if (a[31] == b[31]) begin
      sum = ma + mb;
      s = a[31];
    end else if (ma >= mb) begin
      sum = ma - mb;
      s = a[31];
    end else begin
      sum = mb - ma;
      s = b[31];
    end
    if (sum == 64'd0) return 32'd0;
    return round_pack(s, sum, exp_of(a) - 30, 23, 127, 32);
  endfunction

  function automatic logic [31:0] to_single(input logic [15:0] h);
    logic [63:0] sig;
    if (h[14:10] == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
    sig = (h[14:10] == 5'd0) ? {54'd0, h[9:0]} : {53'd0, 1'b1, h[9:0]};
    return round_pack(h[15], sig, ((h[14:10] == 5'd0) ? 1 : int'(h[14:10])) - 25,
                      23, 127, 32);
  endfunction

  function automatic logic [15:0] to_half(input logic [31:0] f);
    logic [31:0] r;
    if (f[30:23] == 8'hff)
      return (f[22:0] != 23'd0) ? ccm_pkg::HALF_QNAN : {f[31], 15'h7c00};
    r = round_pack(f[31], sig_of(f), exp_of(f), 10, 15, 16);
    return r[15:0];
  endfunction

  function automatic logic [15:0] row_value(input int row, input logic [31:0] r,
                                            input logic [31:0] g, input logic [31:0] b);
    logic [31:0] acc;
    acc = fadd(fmul(coef[3 * row], r), fmul(coef[3 * row + 1], g));
    acc = fadd(acc, fmul(coef[3 * row + 2], b));
    return to_half(acc);
  endfunction

  function automatic ccm_pkg::res_t corrected_pixel(input ccm_pkg::pix_t p);
    ccm_pkg::res_t o;
    logic [31:0] r;
    logic [31:0] g;
    logic [31:0] b;
    r = to_single(p.red_in);
    g = to_single(p.green_in);
    b = to_single(p.blue_in);
    o.red_out = row_value(0, r, g, b);
    o.green_out = row_value(1, r, g, b);
    o.blue_out = row_value(2, r, g, b);
    o.alpha = p.alpha;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_color_matrix_3x3_half_float NOT OK");
      $finish;
    end
  end

  // result side stall pattern
  always @(posedge clk) begin
    if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 99) < 30);
      2: res_stall <= ($urandom_range(0, 99) < 80);
      default: res_stall <= (cycles % 16) < 5;
    endcase
  end

  always @(posedge clk) begin
    ccm_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_q.size() == 0) begin
        $display("unexpected result %h at cycle %0d", res, cycles);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (res.red_out !== want.red_out) report_mismatch("red", res.red_out, want.red_out);
        if (res.green_out !== want.green_out)
          report_mismatch("green", res.green_out, want.green_out);
        if (res.blue_out !== want.blue_out)
          report_mismatch("blue", res.blue_out, want.blue_out);
        if (res.alpha !== want.alpha)
          report_mismatch("alpha", res.alpha, want.alpha);
      end
    end
  end

  task automatic send_pixel(input ccm_pkg::pix_t p);
    pix <= p;
    pix_valid <= 1'b1;
    do @(posedge clk); while (pix_stall);
    pending_q.push_back(corrected_pixel(p));
    if (burst_left == 0) begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    pix_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ccm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    if (idx < ccm_pkg::CFG_LAST) begin
      coef[2 * idx] = data[31:0];
      coef[2 * idx + 1] = data[63:32];
    end else if (idx == ccm_pkg::CFG_LAST) begin
      coef[8] = data[31:0];
    end
  endtask

  task automatic load_matrix();
    write_reg(ccm_pkg::CFG_PAIR_A, {next_coef[1], next_coef[0]});
    write_reg(ccm_pkg::CFG_PAIR_B, {next_coef[3], next_coef[2]});
    write_reg(ccm_pkg::CFG_PAIR_C, {next_coef[5], next_coef[4]});
    write_reg(ccm_pkg::CFG_PAIR_D, {next_coef[7], next_coef[6]});
    write_reg(ccm_pkg::CFG_LAST, {$urandom, next_coef[8]});
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_half();
    logic [15:0] odd [12] = '{16'h0000, 16'h8000, 16'h0001, 16'h83ff, 16'h0400, 16'h7bff,
                              16'hfbff, 16'h7c00, 16'hfc00, 16'h7e00, 16'h7c01, 16'hffff};
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom);
      2: return odd[$urandom_range(0, 11)];
      default: return {1'($urandom), 5'($urandom_range(8, 20)), 10'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return {1'($urandom), 31'd0};
      2: return {1'($urandom), 8'($urandom_range(0, 3)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(115, 130)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_random(input int n);
    ccm_pkg::pix_t p;
    for (int i = 0; i < n; i++) begin
      p.red_in = rand_half();
      p.green_in = rand_half();
      p.blue_in = rand_half();
      p.alpha = 16'($urandom);
      send_pixel(p);
    end
  endtask

  task automatic test_reset_matrix();
    send_random(12);
    wait_idle();
  endtask

  task automatic test_ignored_index();
    write_reg(3'd5, 64'hffff_ffff_ffff_ffff);
    write_reg(3'd6, 64'h3f80_0000_3f80_0000);
    write_reg(3'd7, 64'hdead_beef_1234_5678);
    wr_en <= 1'b0;
    @(posedge clk);
    send_random(8);
    wait_idle();
  endtask

  task automatic test_special_values();
    logic [15:0] vals [16] = '{16'h0000, 16'h8000, 16'h0001, 16'h03ff, 16'h0400, 16'h7bff,
                               16'h7c00, 16'hfc00, 16'h7e00, 16'h7d01, 16'hffff, 16'h3c00,
                               16'hbc00, 16'h5bff, 16'h0200, 16'h3555};
    ccm_pkg::pix_t p;
    // identity with a mixing term
    next_coef = '{32'h3f80_0000, 32'h0, 32'h0, 32'h0, 32'h3f80_0000, 32'h0,
                  32'h3f00_0000, 32'hbf00_0000, 32'h3f80_0000};
    load_matrix();
    for (int i = 0; i < 16; i++) begin
      p = {vals[i], vals[15 - i], vals[(i + 5) % 16], 16'(i)};
      send_pixel(p);
    end
    wait_idle();
  endtask

  task automatic test_range_limits();
    // big gains overflow, tiny gains underflow, one row mixes an all-ones NaN, max float and -0.0
    next_coef = '{32'h477f_e000, 32'h477f_e000, 32'h477f_e000,
                  32'h3380_0000, 32'h0000_0001, 32'hb300_0000,
                  32'hffff_ffff, 32'h7f7f_ffff, 32'h8000_0000};
    load_matrix();
    send_pixel({16'h7bff, 16'h7bff, 16'h7bff, 16'hffff});
    send_pixel({16'h3c00, 16'h0001, 16'h8001, 16'h0000});
    send_pixel({16'h0001, 16'h0000, 16'h0000, 16'h5555});
    send_pixel({16'h1400, 16'h8400, 16'h0c00, 16'haaaa});
    send_random(16);
    wait_idle();
    next_coef = '{32'h7f80_0000, 32'hff80_0000, 32'h0, 32'h0080_0000, 32'h007f_ffff,
                  32'h3f80_0001, 32'h4b80_0000, 32'hcb80_0000, 32'h3380_0000};
    load_matrix();
    send_random(20);
    wait_idle();
  endtask

  task automatic test_random_matrices();
    for (int ph = 0; ph < 10; ph++) begin
      for (int i = 0; i < ccm_pkg::NUM_COEF; i++) next_coef[i] = rand_coef();
      load_matrix();
      send_random(50);
      if (ph == 3) wait_idle();
      send_random(55);
      wait_idle();
    end
  endtask

  initial begin
    for (int i = 0; i < ccm_pkg::NUM_COEF; i++) coef[i] = 32'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_matrix();
    test_ignored_index();
    test_special_values();
    test_range_limits();
    test_random_matrices();
    if (errors == 0) $display("tb_color_matrix_3x3_half_float OK");
    else $display("tb_color_matrix_3x3_half_float NOT OK");
    $finish;
  end

endmodule
